/* rtl/keyed_process_table_macros.svh */
// Assertion helpers included by keyed_process_table.sv.
`ifndef KEYED_PROCESS_TABLE_MACROS_SVH
`define KEYED_PROCESS_TABLE_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define KPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define KPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/kpt_pkg.sv */
package kpt_pkg;

    localparam logic [2:0] OP_ADD           = 3'd0;
    localparam logic [2:0] OP_REMOVE        = 3'd1;
    localparam logic [2:0] OP_SEARCH_ID     = 3'd2;
    localparam logic [2:0] OP_SEARCH_THREAD = 3'd3;
    localparam logic [2:0] OP_FREE_ID       = 3'd4;
    localparam logic [2:0] OP_FIRST         = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] item_handle;
        logic [15:0] key_id;
        logic [31:0] thread_handle;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [31:0] item_out;
        logic [15:0] id_out;
        logic        full_error;
    } t_out;

    typedef struct packed {
        logic [31:0] item;
        logic [15:0] id;
        logic [31:0] thread;
    } t_entry;

    typedef enum logic [1:0] {
        MODE_ITEM,
        MODE_ID,
        MODE_THREAD,
        MODE_ANY
    } t_match_mode;

    typedef struct packed {
        t_match_mode mode;
        logic [31:0] key_item;
        logic [15:0] key_id;
        logic [31:0] key_thread;
    } t_match_ctl;

endpackage

/* rtl/kpt_ram.sv */
module kpt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kpt_match.sv */
module kpt_match (
    input  kpt_pkg::t_match_ctl i_ctl,
    input  kpt_pkg::t_entry     i_entry,
    output logic                o_hit
);

    always_comb begin
        case (i_ctl.mode)
            kpt_pkg::MODE_ITEM:   o_hit = (i_entry.item == i_ctl.key_item);
            kpt_pkg::MODE_ID:     o_hit = (i_entry.id == i_ctl.key_id);
            kpt_pkg::MODE_THREAD: o_hit = (i_entry.thread == i_ctl.key_thread);
            kpt_pkg::MODE_ANY:    o_hit = 1'b1;
            default:              o_hit = 1'b0;
        endcase
    end

endmodule

/* rtl/keyed_process_table.sv */
// Channel | Direction | Handshake                     | Payload
// in      | input     | i_in_valid / o_in_stall       | i_in_data  (kpt_pkg::t_in)
// out     | output    | o_out_valid / i_out_stall     | o_out_data (kpt_pkg::t_out)
//
// Add passes through S_ADD and S_DONE to the output register. Searches, remove, free id
// and first scan the table via one RAM read port and one comparator, one entry a cycle.
// Remove that deletes an entry moves the later entries down.
// Free id rescans from the head per taken id.
// Reset clears the entry count and the control; table contents stay undefined.
// A new item is taken while a finished result waits under stall in the output register.
module keyed_process_table #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kpt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output kpt_pkg::t_out o_out_data
);

    `include "keyed_process_table_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(kpt_pkg::t_entry);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADD   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pend_idx, n_pend_idx;
    logic [2:0]        r_op, n_op;
    logic [31:0]       r_item, n_item;
    logic [15:0]       r_key, n_key;
    logic [31:0]       r_thread, n_thread;
    kpt_pkg::t_out     r_res, n_res;
    logic              r_out_valid, n_out_valid;
    kpt_pkg::t_out     r_out, n_out;

    logic              w_in_xfer;
    logic              w_rd_en;
    logic              w_hit;
    logic              w_match;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [EW-1:0]     w_wdata;
    logic [EW-1:0]     w_rdata;
    kpt_pkg::t_entry   w_entry;
    kpt_pkg::t_match_ctl w_ctl;

    kpt_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_rd_idx[AW-1:0]),
        .o_rdata(w_rdata)
    );

    assign w_entry = kpt_pkg::t_entry'(w_rdata);

    always_comb begin
        w_ctl.key_item   = r_item;
        w_ctl.key_id     = r_key;
        w_ctl.key_thread = r_thread;
        case (r_op)
            kpt_pkg::OP_REMOVE:        w_ctl.mode = kpt_pkg::MODE_ITEM;
            kpt_pkg::OP_SEARCH_THREAD: w_ctl.mode = kpt_pkg::MODE_THREAD;
            kpt_pkg::OP_FIRST:         w_ctl.mode = kpt_pkg::MODE_ANY;
            default:                   w_ctl.mode = kpt_pkg::MODE_ID;
        endcase
    end

    kpt_match u_match (
        .i_ctl  (w_ctl),
        .i_entry(w_entry),
        .o_hit  (w_match)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid && (r_state == S_IDLE);
    assign w_rd_en     = (r_rd_idx < r_count);
    assign w_hit       = r_pend && w_match;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_op        = r_op;
        n_item      = r_item;
        n_key       = r_key;
        n_thread    = r_thread;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata     = {r_item, r_key, r_thread};

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_op     = i_in_data.opcode;
                    n_item   = i_in_data.item_handle;
                    n_key    = i_in_data.key_id;
                    n_thread = i_in_data.thread_handle;
                    n_res    = '0;
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    case (i_in_data.opcode)
                        kpt_pkg::OP_ADD:           n_state = S_ADD;
                        kpt_pkg::OP_REMOVE,
                        kpt_pkg::OP_SEARCH_ID,
                        kpt_pkg::OP_SEARCH_THREAD,
                        kpt_pkg::OP_FREE_ID,
                        kpt_pkg::OP_FIRST:         n_state = S_SCAN;
                        default:                   n_state = S_DONE;
                    endcase
                end
            end
            S_ADD: begin
                if (r_count < CW'(DEPTH)) begin
                    w_we          = 1'b1;
                    n_count       = r_count + 1'b1;
                    n_res.found   = 1'b1;
                end else begin
                    n_res.full_error = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // keep one read in flight ahead of the compare
                n_pend     = w_rd_en;
                n_pend_idx = r_rd_idx[AW-1:0];
                if (w_rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (w_hit) begin
                    case (r_op)
                        kpt_pkg::OP_REMOVE: begin
                            n_rd_idx = CW'(r_pend_idx) + 1'b1;
                            n_pend   = 1'b0;
                            n_state  = S_SHIFT;
                        end
                        kpt_pkg::OP_FREE_ID: begin
                            if (|w_entry.item) begin
                                // id taken: try the next one from the head
                                n_key    = r_key + 16'd1;
                                n_rd_idx = '0;
                                n_pend   = 1'b0;
                            end else begin
                                n_res.found  = 1'b1;
                                n_res.id_out = r_key;
                                n_state      = S_DONE;
                            end
                        end
                        kpt_pkg::OP_FIRST: begin
                            n_res.found    = 1'b1;
                            n_res.item_out = w_entry.item;
                            n_res.id_out   = w_entry.id;
                            n_state        = S_DONE;
                        end
                        default: begin
                            n_res.found    = |w_entry.item;
                            n_res.item_out = w_entry.item;
                            n_state        = S_DONE;
                        end
                    endcase
                end else if (!r_pend && !w_rd_en) begin
                    if (r_op == kpt_pkg::OP_FREE_ID) begin
                        n_res.found  = 1'b1;
                        n_res.id_out = r_key;
                    end
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // move each later entry down by one
                n_pend     = w_rd_en;
                n_pend_idx = r_rd_idx[AW-1:0];
                if (w_rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_pend_idx - 1'b1;
                    w_wdata = w_rdata;
                end
                if (!r_pend && !w_rd_en) begin
                    n_count     = r_count - 1'b1;
                    n_res.found = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_op       <= n_op;
        r_item     <= n_item;
        r_key      <= n_key;
        r_thread   <= n_thread;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    `KPT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count above depth")
    `KPT_ASSERT_NOW(a_write_in_range, i_clk, i_rst_n, w_we, CW'(w_waddr) <= r_count, "write past tail")
    `KPT_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, w_in_xfer, r_state != S_IDLE, "idle after transfer")
    `KPT_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_DONE) && !(r_out_valid && i_out_stall), o_out_valid, "result not loaded")

endmodule
